/* hw/rtl/falt_pkg.sv */
`timescale 1ns / 1ps
package falt_pkg;

  localparam int unsigned NUM_SLOTS = 256;
  localparam int unsigned SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned TOTAL_W   = 9;
  localparam int unsigned SHIFT_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned WIDE_W    = WORD_W + 16;

  localparam logic [SHIFT_W-1:0] MAX_SHIFT = SHIFT_W'(16);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(511);
  localparam logic [WORD_W-1:0]  COUNT_MAX = {WORD_W{1'b1}};

  localparam logic [WORD_W-1:0] BASE_RESET  = WORD_W'(1000);
  localparam logic [WORD_W-1:0] CAP_RESET   = WORD_W'(60000);
  localparam logic [WORD_W-1:0] LIMIT_RESET = WORD_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE  = 2'd0,
    REG_CAP   = 2'd1,
    REG_LIMIT = 2'd2,
    REG_NONE  = 2'd3
  } falt_reg_e;

  typedef enum logic [1:0] {
    OP_CHECK   = 2'd0,
    OP_FAIL    = 2'd1,
    OP_SUCCEED = 2'd2,
    OP_NONE    = 2'd3
  } falt_op_e;

  typedef struct packed {
    falt_op_e            op;
    logic                slot_ok;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   now;
  } falt_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] base_window;
    logic [WORD_W-1:0] cap_window;
    logic [WORD_W-1:0] fail_limit;
  } falt_cfg_t;

  typedef struct packed {
    logic               valid;
    logic               status;
    logic [TOTAL_W-1:0] tracked;
  } falt_res_t;

endpackage

/* hw/rtl/falt_front.sv */
`timescale 1ns / 1ps
module falt_front import falt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation_i,
  input  logic [IDX_W-1:0]  slot_index_i,
  input  logic [TIME_W-1:0] current_time_i,
  output logic              q_valid_o,
  output falt_item_t        q_item_o,
  input  logic              q_pop_i
);

  falt_item_t  entry_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push;
  logic        pop;
  falt_item_t  item_in;

  always_comb begin
    item_in.op      = falt_op_e'(operation_i);
    item_in.slot_ok = ({{(32-IDX_W){1'b0}}, slot_index_i} < 32'(NUM_SLOTS));
    item_in.slot    = SLOT_W'(slot_index_i);
    item_in.now     = current_time_i;
  end

  assign busy      = (count_q == 2'd2);
  assign push      = start && !busy;
  assign pop       = q_pop_i && (count_q != 2'd0);
  assign q_valid_o = (count_q != 2'd0);
  assign q_item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

/* hw/rtl/falt_back.sv */
`timescale 1ns / 1ps
module falt_back import falt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  falt_cfg_t  cfg_i,
  input  logic       q_valid_i,
  input  falt_item_t q_item_i,
  output logic       q_pop_o,
  output falt_res_t  res_o
);

  typedef enum logic [5:0] {
    B_IDLE   = 6'b000001,
    B_READ   = 6'b000010,
    B_INC    = 6'b000100,
    B_SHIFT  = 6'b001000,
    B_WIN    = 6'b010000,
    B_COMMIT = 6'b100000
  } falt_state_e;

  falt_state_e state_q, state_d;

  logic [WORD_W-1:0] cnt_mem [NUM_SLOTS];
  logic [TIME_W-1:0] dl_mem  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] ent_valid_q;
  logic [NUM_SLOTS-1:0] seen_q;
  logic [TOTAL_W-1:0]   total_q;

  falt_item_t        item_q;
  logic [WORD_W-1:0] rd_cnt_q;
  logic [TIME_W-1:0] rd_dl_q;
  logic              rd_ok_q;
  logic              rd_seen_q;
  logic [WORD_W-1:0] cnt_q;
  logic [TIME_W-1:0] dl_q;
  logic              ge_q;
  logic              chk_q;
  logic [SHIFT_W-1:0] sh_q;
  logic [WORD_W-1:0] win_q;
  falt_res_t         res_q;

  logic [WORD_W-1:0] cur_cnt;
  logic [TIME_W-1:0] cur_dl;
  logic [WORD_W-1:0] over;
  logic [WIDE_W-1:0] shifted;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] dl_new;
  logic              wr_en;
  logic [WORD_W-1:0] wr_cnt;
  logic [TIME_W-1:0] wr_dl;
  logic              status;
  logic              mark_seen;

  assign q_pop_o = (state_q == B_IDLE) && q_valid_i;
  assign res_o   = res_q;

  always_comb begin
    case (state_q)
      B_IDLE:   state_d = q_valid_i ? B_READ : B_IDLE;
      B_READ:   state_d = B_INC;
      B_INC:    state_d = B_SHIFT;
      B_SHIFT:  state_d = B_WIN;
      B_WIN:    state_d = B_COMMIT;
      B_COMMIT: state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  always_comb begin
    cur_cnt = rd_ok_q ? rd_cnt_q : '0;
    cur_dl  = rd_ok_q ? rd_dl_q : '0;
    over    = cnt_q - cfg_i.fail_limit;
    shifted = {{(WIDE_W-WORD_W){1'b0}}, cfg_i.base_window} << sh_q;
    sum     = {1'b0, item_q.now} + {{(TIME_W+1-WORD_W){1'b0}}, win_q};
    dl_new  = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_cnt    = cnt_q;
    wr_dl     = dl_q;
    status    = 1'b0;
    mark_seen = 1'b0;
    case (item_q.op)
      OP_CHECK: begin
        status = item_q.slot_ok && chk_q;
      end
      OP_FAIL: begin
        if (!item_q.slot_ok) begin
          status = 1'b1;
        end else begin
          wr_en     = 1'b1;
          mark_seen = !rd_seen_q;
          status    = ge_q;
          if (ge_q) begin
            wr_dl = dl_new;
          end
        end
      end
      OP_SUCCEED: begin
        if (item_q.slot_ok) begin
          wr_en  = 1'b1;
          wr_cnt = '0;
          wr_dl  = '0;
        end
      end
      default: begin
        status = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      ent_valid_q <= '0;
      seen_q      <= '0;
      total_q     <= '0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      res_q.valid <= (state_q == B_COMMIT);
      if (state_q == B_COMMIT) begin
        res_q.status <= status;
        res_q.tracked <= (mark_seen && (total_q != TOTAL_MAX)) ? total_q + 1'b1 : total_q;
        if (mark_seen) begin
          seen_q[item_q.slot] <= 1'b1;
          if (total_q != TOTAL_MAX) begin
            total_q <= total_q + 1'b1;
          end
        end
        if (wr_en) begin
          ent_valid_q[item_q.slot] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
    if (state_q == B_READ) begin
      rd_cnt_q  <= cnt_mem[item_q.slot];
      rd_dl_q   <= dl_mem[item_q.slot];
      rd_ok_q   <= ent_valid_q[item_q.slot];
      rd_seen_q <= seen_q[item_q.slot];
    end
    if (state_q == B_INC) begin
      cnt_q <= (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
      dl_q  <= cur_dl;
    end
    if (state_q == B_SHIFT) begin
      ge_q  <= (cnt_q >= cfg_i.fail_limit);
      sh_q  <= (over < WORD_W'(MAX_SHIFT)) ? over[SHIFT_W-1:0] : MAX_SHIFT;
      chk_q <= (item_q.now < dl_q);
    end
    if (state_q == B_WIN) begin
      win_q <= (shifted > {{(WIDE_W-WORD_W){1'b0}}, cfg_i.cap_window}) ?
               cfg_i.cap_window : shifted[WORD_W-1:0];
    end
    if ((state_q == B_COMMIT) && wr_en) begin
      cnt_mem[item_q.slot] <= wr_cnt;
      dl_mem[item_q.slot]  <= wr_dl;
    end
  end

endmodule

/* hw/rtl/failed_attempt_lockout_table.sv */
`timescale 1ns / 1ps
// Lockout table with exponential backoff over 256 slots. A request is taken
// when start is high and busy is low; a two-entry queue holds requests, so
// busy rises only when two are waiting. The back end handles one request at
// a time (dequeue, table read, count update, shift select, window cap,
// deadline add and write-back) and pops the next request only after the
// write-back of the last one; result_valid_o is registered and rises as
// the back end leaves its write-back state. Each result is on status_o and
// tracked_count_o for one cycle with result_valid_o high and cannot be
// held off. The slot tables read as zero after reset through per-slot
// valid flops, so no clearing pass is needed. Write configuration only
// while no request is pending.
module failed_attempt_lockout_table import falt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           operation_i,
  input  logic [IDX_W-1:0]     slot_index_i,
  input  logic [TIME_W-1:0]    current_time_i,
  output logic                 result_valid_o,
  output logic                 status_o,
  output logic [TOTAL_W-1:0]   tracked_count_o
);

  falt_cfg_t  cfg_q;
  logic       q_valid;
  falt_item_t q_item;
  logic       q_pop;
  falt_res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_window <= BASE_RESET;
      cfg_q.cap_window  <= CAP_RESET;
      cfg_q.fail_limit  <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (falt_reg_e'(cfg_index_i))
        REG_BASE:  cfg_q.base_window <= cfg_wdata_i;
        REG_CAP:   cfg_q.cap_window  <= cfg_wdata_i;
        REG_LIMIT: cfg_q.fail_limit  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  falt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .slot_index_i   (slot_index_i),
    .current_time_i (current_time_i),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item),
    .q_pop_i        (q_pop)
  );

  falt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .res_o     (res)
  );

  assign result_valid_o  = res.valid;
  assign status_o        = res.status;
  assign tracked_count_o = res.tracked;

endmodule

/* hw/rtl/falt_checker.sv */
`timescale 1ns / 1ps
module falt_checker import falt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               result_valid_o,
  input logic [TOTAL_W-1:0] tracked_count_o
);

  a_result_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("results on consecutive cycles");

  a_tracked_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (tracked_count_o >= $past(tracked_count_o)))
    else $error("tracked count decreased");

  a_tracked_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tracked_count_o <= TOTAL_W'(NUM_SLOTS))
    else $error("tracked count above slot count");

  a_tracked_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni) && !result_valid_o) |-> $stable(tracked_count_o))
    else $error("tracked count moved without a result");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transfer");

endmodule

bind failed_attempt_lockout_table falt_checker u_falt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_valid_o  (result_valid_o),
  .tracked_count_o (tracked_count_o)
);

/* dv/tb_failed_attempt_lockout_table.sv */
`timescale 1ns / 1ps
module tb_failed_attempt_lockout_table;
  import falt_pkg::*;

  localparam int                WATCHDOG_LIMIT = 2000;
  localparam int                NUM_PHASES     = 8;
  localparam int                PHASE_ITEMS    = 125;
  localparam logic [TIME_W-1:0] T_MAX          = {TIME_W{1'b1}};
  localparam logic [WORD_W-1:0] W_MAX          = {WORD_W{1'b1}};

  typedef struct packed {
    logic               status;
    logic [TOTAL_W-1:0] tracked;
  } verdict_t;

  typedef struct {
    bit                 is_cfg;
    falt_reg_e          reg_idx;
    logic [WORD_W-1:0]  reg_val;
    falt_op_e           op;
    logic [IDX_W-1:0]   slot;
    logic [TIME_W-1:0]  now;
    bit                 typed;
    logic               status;
    logic [TOTAL_W-1:0] tracked;
  } stim_row_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [WORD_W-1:0]    cfg_wdata_i    = '0;
  logic                 start          = 1'b0;
  logic                 busy;
  logic [1:0]           operation_i    = '0;
  logic [IDX_W-1:0]     slot_index_i   = '0;
  logic [TIME_W-1:0]    current_time_i = '0;
  logic                 result_valid_o;
  logic                 status_o;
  logic [TOTAL_W-1:0]   tracked_count_o;

  logic [WORD_W-1:0]  cur_base  = BASE_RESET;
  logic [WORD_W-1:0]  cur_cap   = CAP_RESET;
  logic [WORD_W-1:0]  cur_limit = LIMIT_RESET;
  logic [WORD_W-1:0]  slot_fail_cnt [NUM_SLOTS];
  logic [TIME_W-1:0]  slot_deadline [NUM_SLOTS];
  logic               slot_seen     [NUM_SLOTS];
  logic [TOTAL_W-1:0] seen_total = '0;

  verdict_t pending_verdicts [$];
  int       err_cnt      = 0;
  int       sent_cnt     = 0;
  int       result_cnt   = 0;
  int       blocked_cnt  = 0;
  int       reg_wr_cnt   = 0;
  int       idle_cycles  = 0;
  int       peak_tracked = 0;

  failed_attempt_lockout_table u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .slot_index_i   (slot_index_i),
    .current_time_i (current_time_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .tracked_count_o(tracked_count_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic verdict_t predict_lockout(falt_op_e op, logic [IDX_W-1:0] slot,
                                               logic [TIME_W-1:0] now);
    verdict_t          v;
    bit                slot_ok;
    logic [WORD_W-1:0] over;
    logic [SHIFT_W-1:0] sh;
    logic [TIME_W-1:0] dur;
    logic [TIME_W:0]   sum;
    v.status = 1'b0;
    slot_ok  = (32'(slot) < NUM_SLOTS);
    case (op)
      OP_CHECK: begin
        if (slot_ok && now < slot_deadline[slot]) v.status = 1'b1;
      end
      OP_FAIL: begin
        if (!slot_ok) begin
          v.status = 1'b1;
        end else begin
          if (!slot_seen[slot]) begin
            slot_seen[slot] = 1'b1;
            if (seen_total < TOTAL_MAX) seen_total = seen_total + 1'b1;
          end
          if (slot_fail_cnt[slot] != COUNT_MAX) slot_fail_cnt[slot] = slot_fail_cnt[slot] + 1;
          if (slot_fail_cnt[slot] >= cur_limit) begin
            over = slot_fail_cnt[slot] - cur_limit;
            sh   = (over < 32'(MAX_SHIFT)) ? over[SHIFT_W-1:0] : MAX_SHIFT;
            dur  = {32'd0, cur_base} << sh;
            if (dur > {32'd0, cur_cap}) dur = {32'd0, cur_cap};
            sum  = {1'b0, now} + {1'b0, dur};
            slot_deadline[slot] = sum[TIME_W] ? T_MAX : sum[TIME_W-1:0];
            v.status = 1'b1;
          end
        end
      end
      OP_SUCCEED: begin
        if (slot_ok) begin
          slot_fail_cnt[slot] = '0;
          slot_deadline[slot] = '0;
        end
      end
      default: ;
    endcase
    v.tracked = seen_total;
    return v;
  endfunction

  function automatic stim_row_t req_row(falt_op_e op, logic [IDX_W-1:0] slot,
                                        logic [TIME_W-1:0] now, bit typed,
                                        logic st, logic [TOTAL_W-1:0] tr);
    return '{1'b0, REG_NONE, 32'd0, op, slot, now, typed, st, tr};
  endfunction

  function automatic stim_row_t cfg_row(falt_reg_e idx, logic [WORD_W-1:0] val);
    return '{1'b1, idx, val, OP_NONE, 8'd0, 64'd0, 1'b0, 1'b0, 9'd0};
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic release_start;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic write_reg(input falt_reg_e idx, input logic [WORD_W-1:0] val);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_BASE:  cur_base  = val;
      REG_CAP:   cur_cap   = val;
      REG_LIMIT: cur_limit = val;
      default: ;
    endcase
    reg_wr_cnt++;
  endtask

  task automatic send_request(input falt_op_e op, input logic [IDX_W-1:0] slot,
                              input logic [TIME_W-1:0] now, input bit typed,
                              input logic st, input logic [TOTAL_W-1:0] tr);
    verdict_t v;
    @(negedge clk_i);
    start          = 1'b1;
    operation_i    = op;
    slot_index_i   = slot;
    current_time_i = now;
    do @(posedge clk_i); while (busy);
    v = predict_lockout(op, slot, now);
    if (typed) v = '{st, tr};
    pending_verdicts.push_back(v);
    sent_cnt++;
  endtask

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && result_valid_o) begin
      result_cnt++;
      if (status_o) blocked_cnt++;
      if (int'(tracked_count_o) > peak_tracked) peak_tracked = int'(tracked_count_o);
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result with none pending: status %0b tracked %0d",
                                  status_o, tracked_count_o));
      end else begin
        want = pending_verdicts.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status exp %0b act %0b", want.status, status_o));
        if (tracked_count_o !== want.tracked)
          report_mismatch($sformatf("tracked_count exp %0d act %0d",
                                    want.tracked, tracked_count_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL failed_attempt_lockout_table");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t         rows [$];
    logic [IDX_W-1:0]  hot [4];
    logic [TIME_W-1:0] t_now;
    logic [TIME_W-1:0] t_req;
    logic [TIME_W-1:0] adv;
    logic [WORD_W-1:0] base_v, cap_v, lim_v;
    logic [IDX_W-1:0]  slot;
    falt_op_e          op;
    bit                idle_on;
    int                r;

    for (int s = 0; s < NUM_SLOTS; s++) begin
      slot_fail_cnt[s] = '0;
      slot_deadline[s] = '0;
      slot_seen[s]     = 1'b0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    rows.push_back(req_row(OP_CHECK,   8'd0,   64'd0, 1, 1'b0, 9'd0));
    rows.push_back(req_row(OP_CHECK,   8'd255, T_MAX, 1, 1'b0, 9'd0));
    rows.push_back(req_row(OP_NONE,    8'd7,   64'd5, 1, 1'b0, 9'd0));
    rows.push_back(req_row(OP_SUCCEED, 8'd9,   64'd0, 1, 1'b0, 9'd0));
    repeat (4) rows.push_back(req_row(OP_FAIL, 8'd3, 64'd100, 1, 1'b0, 9'd1));
    rows.push_back(req_row(OP_FAIL,    8'd3, 64'd100,  1, 1'b1, 9'd1));
    rows.push_back(req_row(OP_CHECK,   8'd3, 64'd1099, 1, 1'b1, 9'd1));
    rows.push_back(req_row(OP_CHECK,   8'd3, 64'd1100, 1, 1'b0, 9'd1));
    rows.push_back(req_row(OP_FAIL,    8'd3, 64'd2000, 0, 1'b0, 9'd0));
    rows.push_back(req_row(OP_SUCCEED, 8'd3, 64'd2001, 1, 1'b0, 9'd1));
    rows.push_back(req_row(OP_CHECK,   8'd3, 64'd2002, 1, 1'b0, 9'd1));
    rows.push_back(cfg_row(REG_LIMIT, 32'd1));
    rows.push_back(req_row(OP_FAIL,  8'd255, T_MAX - 64'd10, 0, 1'b0, 9'd0));
    rows.push_back(req_row(OP_CHECK, 8'd255, T_MAX - 64'd1,  0, 1'b0, 9'd0));
    rows.push_back(cfg_row(REG_BASE, 32'd0));
    rows.push_back(req_row(OP_FAIL,  8'd4, 64'd50, 0, 1'b0, 9'd0));
    rows.push_back(req_row(OP_CHECK, 8'd4, 64'd50, 0, 1'b0, 9'd0));
    rows.push_back(cfg_row(REG_BASE, W_MAX));
    rows.push_back(cfg_row(REG_CAP, 32'd1));
    rows.push_back(req_row(OP_FAIL,  8'd5, 64'd0, 0, 1'b0, 9'd0));
    rows.push_back(req_row(OP_CHECK, 8'd5, 64'd0, 0, 1'b0, 9'd0));
    rows.push_back(req_row(OP_CHECK, 8'd5, 64'd1, 0, 1'b0, 9'd0));
    rows.push_back(cfg_row(REG_LIMIT, 32'd0));
    rows.push_back(cfg_row(REG_NONE, 32'hA5A5_A5A5));
    rows.push_back(req_row(OP_FAIL,  8'd6, 64'd10, 0, 1'b0, 9'd0));
    rows.push_back(req_row(OP_CHECK, 8'd6, 64'd10, 0, 1'b0, 9'd0));

    foreach (rows[k]) begin
      if (rows[k].is_cfg) begin
        release_start();
        write_reg(rows[k].reg_idx, rows[k].reg_val);
      end else begin
        send_request(rows[k].op, rows[k].slot, rows[k].now, rows[k].typed,
                     rows[k].status, rows[k].tracked);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      release_start();
      case (p)
        0: begin base_v = BASE_RESET; cap_v = CAP_RESET; lim_v = LIMIT_RESET; end
        1: begin base_v = W_MAX; cap_v = W_MAX; lim_v = W_MAX; end
        2: begin base_v = 32'd1; cap_v = W_MAX; lim_v = 32'd0; end
        default: begin
          case ($urandom_range(0, 5))
            0: base_v = 32'd0;
            1: base_v = 32'd1;
            2: base_v = BASE_RESET;
            3: base_v = $urandom_range(1, 5000);
            4: base_v = W_MAX;
            default: base_v = $urandom;
          endcase
          case ($urandom_range(0, 4))
            0: cap_v = 32'd1;
            1: cap_v = CAP_RESET;
            2: cap_v = $urandom_range(1, 20000);
            3: cap_v = W_MAX;
            default: cap_v = base_v;
          endcase
          case ($urandom_range(0, 4))
            0: lim_v = 32'd0;
            1: lim_v = 32'd1;
            2: lim_v = LIMIT_RESET;
            3: lim_v = $urandom_range(2, 20);
            default: lim_v = W_MAX;
          endcase
        end
      endcase
      write_reg(REG_BASE, base_v);
      write_reg(REG_CAP, cap_v);
      write_reg(REG_LIMIT, lim_v);
      write_reg(REG_NONE, $urandom);

      foreach (hot[h]) hot[h] = IDX_W'($urandom);
      t_now   = (p % 4 == 3) ? T_MAX - 64'($urandom_range(0, 200000)) : {32'd0, $urandom};
      idle_on = 1'b0;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 25 == 0) idle_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 1) == 1);
        if (idle_on && $urandom_range(0, 2) == 0) begin
          release_start();
          repeat ($urandom_range(0, 12)) @(negedge clk_i);
        end
        adv   = 64'($urandom_range(0, 1500));
        t_now = (t_now > T_MAX - adv) ? T_MAX : t_now + adv;
        if ($urandom_range(0, 9) < 7) begin
          slot = hot[$urandom_range(0, 3)];
          r    = $urandom_range(0, 19);
          op   = (r < 10) ? OP_FAIL : (r < 17) ? OP_CHECK : (r < 19) ? OP_SUCCEED : OP_NONE;
          t_req = t_now;
        end else begin
          slot  = IDX_W'($urandom);
          op    = falt_op_e'(2'($urandom_range(0, 3)));
          t_req = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : t_now;
        end
        send_request(op, slot, t_req, 0, 1'b0, '0);
      end
    end

    release_start();
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Ran %0d requests through %0d register writes: %0d results, %0d blocked.",
             sent_cnt, reg_wr_cnt, result_cnt, blocked_cnt);
    $display("Tracked slot count peaked at %0d; %0d mismatches.", peak_tracked, err_cnt);
    if (err_cnt == 0) begin
      $display("PASS failed_attempt_lockout_table");
    end else begin
      $display("FAIL failed_attempt_lockout_table");
    end
    $finish;
  end

endmodule
